>>> hw/rtl/bfd_pkg.sv
// Shared types and constants of the bridge frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package bfd_pkg;

    localparam int unsigned MAX_FRAME_DEF   = 32;
    localparam int unsigned CHUNK_BYTES_DEF = 16;
    localparam int unsigned MAX_RESULTS     = 24;
    localparam int unsigned DATA_W          = 112;

    localparam logic [7:0]  SYNC_BYTE      = 8'hA5;
    localparam logic [7:0]  PROTO_VER      = 8'd2;
    localparam logic [7:0]  SPACE_CHAR     = 8'h20;
    localparam logic [15:0] FULL_SCALE_RST = 16'd4095;
    localparam logic [7:0]  SEG_ID_RST     = 8'd0;

    localparam logic [7:0] T_OUTPUT  = 8'd2;
    localparam logic [7:0] T_DIG_A   = 8'd3;
    localparam logic [7:0] T_DIG_B   = 8'd4;
    localparam logic [7:0] T_ANALOG  = 8'd5;
    localparam logic [7:0] T_GROUP   = 8'd6;
    localparam logic [7:0] T_SEGMENT = 8'd7;

    localparam logic REG_FULL_SCALE = 1'b0;
    localparam logic REG_SEG_ID     = 1'b1;

    typedef enum logic [2:0] {
        K_DIGITAL, K_ANALOG, K_OUTPUT, K_GROUP, K_SEGMENT, K_INVALID, K_DROPPED
    } t_kind;

    typedef enum logic [2:0] {
        C_DROP, C_INVALID, C_DIG, C_ANA, C_OUT, C_GRP, C_SEG, C_NONE
    } t_cls;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV, S_GRP_RD, S_GRP_EMIT, S_SEG_CHK, S_SEG_RD,
        S_SEG_WR, S_SEG_END, S_ASM, S_SEG_EMIT
    } t_state;

    typedef struct packed {
        logic  accept;
        logic  emit;
        t_kind ekind;
        logic  frame_clr;
        logic  div_start;
        logic  idx_clr;
        logic  idx_inc;
        logic  rd_en;
        logic  rd_seg;
        logic  seg_load;
        logic  chunk_wr;
        logic  asm_clr;
        logic  asm_step;
    } t_cmd;

    typedef struct packed {
        t_cls cls;
        logic seg_mismatch;
        logic seg_cnt_zero;
        logic seg_wr_last;
        logic seg_done;
        logic grp_last;
        logic div_busy;
        logic asm_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> hw/rtl/bfd_datapath.sv
// Datapath of the frame decoder: frame memory, checks, divider, digit assembly, output word.
`timescale 1ns / 1ps
`default_nettype none
module bfd_datapath
    import bfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME   = MAX_FRAME_DEF,
    parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic [7:0]        i_data,
    input  wire logic [15:0]       i_full_scale,
    input  wire logic [7:0]        i_seg_id,
    input  wire logic              i_tready,
    output logic                   o_tvalid,
    output logic [2:0]             o_tuser,
    output logic [DATA_W-1:0]      o_tdata,
    output logic                   o_tlast
);

    localparam int AW  = $clog2(MAX_FRAME);
    localparam int CW  = $clog2(MAX_FRAME + 1);
    localparam int CHW = $clog2(CHUNK_BYTES);
    localparam int PW  = (CHW >= 4) ? CHW + 1 : 4;
    localparam int NCAP = 11;

    // Frame gathering.
    logic [7:0]    r_frame [MAX_FRAME];
    logic [7:0]    r_rdata;
    logic [CW-1:0] r_count;
    logic [7:0]    r_xor;
    logic          r_ovf;
    logic [7:0]    r_cap [NCAP];
    logic [AW-1:0] r_idx;

    // Divider.
    logic [25:0] r_rem;
    logic [9:0]  r_quot;
    logic [3:0]  r_dstep;
    logic        r_div_busy;

    // Segment text.
    logic [7:0]    r_seg_len, r_seg_sub, r_seg_pts, r_seg_mask;
    logic [7:0]    r_chunk [CHUNK_BYTES];
    logic [7:0]    r_digit [8];
    logic [2:0]    r_dsel;
    logic [PW-1:0] r_pos;

    // Output word.
    logic        r_out_valid;
    t_kind       r_kind;
    logic [7:0]  r_type, r_mod, r_chan, r_grp;
    logic        r_val, r_last;
    logic [15:0] r_raw;
    logic [9:0]  r_pct;
    logic [23:0] r_th, r_tl;

    logic [7:0]  p0, p1, p2, p3, p4, p5, p6, len, ftype, rx_type, grp_n;
    logic        hdr_ok, out_free;
    logic [15:0] raw, lim;
    logic [25:0] trial;
    logic [AW-1:0] rd_addr;
    logic [CHW-1:0] wr_idx;
    logic [8:0]  seg_off_sum;

    assign ftype = r_cap[2];
    assign len   = r_cap[3];
    assign p0    = r_cap[4];
    assign p1    = r_cap[5];
    assign p2    = r_cap[6];
    assign p3    = r_cap[7];
    assign p4    = r_cap[8];
    assign p5    = r_cap[9];
    assign p6    = r_cap[10];

    assign rx_type  = (r_count >= CW'(3)) ? ftype : 8'd0;
    assign hdr_ok   = (r_count >= CW'(5)) && (r_cap[0] == SYNC_BYTE) &&
                      (r_cap[1] == PROTO_VER) && (r_xor == 8'd0) &&
                      (9'(r_count) == 9'(len) + 9'd5);
    assign raw      = {p3, p2};
    assign lim      = (raw < i_full_scale) ? raw : i_full_scale;
    assign trial    = 26'(i_full_scale) << r_dstep;
    assign grp_n    = (p2 > 8'(MAX_RESULTS)) ? 8'(MAX_RESULTS) : p2;
    assign out_free = !r_out_valid || i_tready;
    assign rd_addr  = i_cmd.rd_seg ? AW'(32'(r_idx) + 32'd11) : AW'(32'(r_idx) + 32'd7);
    assign wr_idx   = CHW'(9'(p1) + 9'(r_idx));
    assign seg_off_sum = 9'(p1) + 9'(p3);

    always_comb begin
        if (r_ovf) begin
            o_stat.cls = C_DROP;
        end else if (!hdr_ok) begin
            o_stat.cls = C_INVALID;
        end else if ((ftype == T_DIG_A || ftype == T_DIG_B) && len == 8'd3) begin
            o_stat.cls = C_DIG;
        end else if (ftype == T_ANALOG && len == 8'd4) begin
            o_stat.cls = C_ANA;
        end else if (ftype == T_OUTPUT && len == 8'd2) begin
            o_stat.cls = C_OUT;
        end else if (ftype == T_GROUP && len >= 8'd4 && 9'(len) == 9'(p2) + 9'd3) begin
            o_stat.cls = C_GRP;
        end else if (ftype == T_SEGMENT && len >= 8'd7 && p0 == i_seg_id &&
                     9'(p3) + 9'd7 == 9'(len) &&
                     seg_off_sum <= 9'(CHUNK_BYTES - 1) &&
                     9'(p2) < 9'(CHUNK_BYTES)) begin
            o_stat.cls = C_SEG;
        end else begin
            o_stat.cls = C_NONE;
        end
        o_stat.seg_mismatch = (p2 != r_seg_len) || (p4 != r_seg_sub) ||
                              (p5 != r_seg_pts) || (p6 != r_seg_mask);
        o_stat.seg_cnt_zero = (p3 == 8'd0);
        o_stat.seg_wr_last  = (8'(r_idx) == p3 - 8'd1);
        o_stat.seg_done     = (seg_off_sum == 9'(r_seg_len));
        o_stat.grp_last     = (8'(r_idx) == grp_n - 8'd1);
        o_stat.div_busy     = r_div_busy;
        o_stat.asm_last     = (r_dsel == 3'd0);
        o_stat.out_free     = out_free;
    end

    // Frame memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_count < CW'(MAX_FRAME)) begin
            r_frame[r_count[AW-1:0]] <= i_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_frame[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_count < CW'(MAX_FRAME)) begin
            for (int k = 0; k < NCAP; k++) begin
                if (r_count == CW'(k)) begin
                    r_cap[k] <= i_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_xor   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.frame_clr) begin
                r_count <= '0;
                r_xor   <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.accept) begin
                if (r_count < CW'(MAX_FRAME)) begin
                    r_count <= r_count + CW'(1);
                    r_xor   <= r_xor ^ i_data;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Restoring divider: one quotient bit per cycle, ten bits in all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
        end else if (r_div_busy && r_dstep == 4'd0) begin
            r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem   <= 26'(lim) * 26'(1000);
            r_quot  <= '0;
            r_dstep <= 4'd9;
        end else if (r_div_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_quot[r_dstep] <= 1'b1;
            end
            if (r_dstep != 4'd0) begin
                r_dstep <= r_dstep - 4'd1;
            end
        end
    end

    // Segment state, chunk store and digit store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len  <= '0;
            r_seg_sub  <= '0;
            r_seg_pts  <= '0;
            r_seg_mask <= '0;
            for (int k = 0; k < CHUNK_BYTES; k++) begin
                r_chunk[k] <= '0;
            end
            for (int k = 0; k < 8; k++) begin
                r_digit[k] <= SPACE_CHAR;
            end
            r_dsel <= '0;
            r_pos  <= '0;
        end else begin
            if (i_cmd.seg_load && p1 == 8'd0) begin
                r_seg_len  <= p2;
                r_seg_sub  <= p4;
                r_seg_pts  <= p5;
                r_seg_mask <= p6;
                for (int k = 0; k < CHUNK_BYTES; k++) begin
                    r_chunk[k] <= '0;
                end
            end
            if (i_cmd.chunk_wr) begin
                r_chunk[wr_idx] <= r_rdata;
            end
            if (i_cmd.asm_clr) begin
                r_dsel <= 3'd7;
                r_pos  <= '0;
            end else if (i_cmd.asm_step) begin
                // Placed digits take chunk bytes in order; past the text length they blank.
                if (r_seg_mask[r_dsel]) begin
                    if (8'(r_pos) < r_seg_len && 32'(r_pos) < CHUNK_BYTES) begin
                        r_digit[r_dsel] <= r_chunk[r_pos[CHW-1:0]];
                        r_pos <= r_pos + PW'(1);
                    end else begin
                        r_digit[r_dsel] <= SPACE_CHAR;
                    end
                end
                r_dsel <= r_dsel - 3'd1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= i_cmd.ekind;
            r_type <= ftype;
            r_mod  <= '0;
            r_chan <= '0;
            r_val  <= 1'b0;
            r_grp  <= '0;
            r_raw  <= '0;
            r_pct  <= '0;
            r_th   <= '0;
            r_tl   <= '0;
            r_last <= 1'b1;
            case (i_cmd.ekind)
                K_DIGITAL: begin
                    r_mod  <= p0;
                    r_chan <= p1;
                    r_val  <= (p2 != 8'd0);
                end
                K_ANALOG: begin
                    r_mod <= p0;
                    r_raw <= raw;
                    r_pct <= (i_full_scale == 16'd0) ? 10'd0 : r_quot;
                end
                K_OUTPUT: begin
                    r_chan <= p0;
                    r_val  <= (p1 != 8'd0);
                end
                K_GROUP: begin
                    r_mod  <= p0;
                    r_val  <= (p1 != 8'd0);
                    r_chan <= 8'(r_idx) << 3;
                    r_grp  <= r_rdata;
                    r_last <= o_stat.grp_last;
                end
                K_SEGMENT: begin
                    r_mod <= p0;
                    r_th  <= {r_digit[5], r_digit[4], r_digit[3]};
                    r_tl  <= {r_digit[2], r_digit[1], r_digit[0]};
                end
                K_INVALID: begin
                    r_type <= rx_type;
                end
                K_DROPPED: begin
                    r_type <= '0;
                end
                default: begin
                    r_type <= '0;
                end
            endcase
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_last;
    assign o_tdata  = {5'd0, r_tl, r_th, r_pct, r_raw, r_grp, r_val, r_chan, r_mod, r_type};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FRAME))
        else $error("byte count beyond frame buffer");
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CW'(MAX_FRAME))
        else $error("overflow flagged with buffer not full");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result word overwritten before it was taken");

endmodule
`default_nettype wire

>>> hw/rtl/bfd_ctrl.sv
// Controller state machine of the frame decoder.
`timescale 1ns / 1ps
`default_nettype none
module bfd_ctrl
    import bfd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_tvalid,
    input  wire logic  i_tlast,
    output logic       o_tready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_tready     = (r_state == S_IDLE);
        o_cmd.accept = i_tvalid && (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_tlast) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_stat.cls)
                    C_DROP, C_INVALID, C_DIG, C_OUT: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.frame_clr = 1'b1;
                            n_state         = S_IDLE;
                        end
                        case (i_stat.cls)
                            C_DROP:    o_cmd.ekind = K_DROPPED;
                            C_INVALID: o_cmd.ekind = K_INVALID;
                            C_DIG:     o_cmd.ekind = K_DIGITAL;
                            default:   o_cmd.ekind = K_OUTPUT;
                        endcase
                    end
                    C_ANA: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                    C_GRP: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_GRP_RD;
                    end
                    C_SEG: begin
                        o_cmd.seg_load = 1'b1;
                        n_state        = S_SEG_CHK;
                    end
                    default: begin
                        o_cmd.frame_clr = 1'b1;
                        n_state         = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.ekind = K_ANALOG;
                if (!i_stat.div_busy && i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.frame_clr = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_GRP_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_GRP_EMIT;
            end
            S_GRP_EMIT: begin
                o_cmd.ekind = K_GROUP;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.grp_last) begin
                        o_cmd.frame_clr = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_GRP_RD;
                    end
                end
            end
            S_SEG_CHK: begin
                o_cmd.ekind = K_INVALID;
                if (i_stat.seg_mismatch) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.frame_clr = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.seg_cnt_zero) begin
                    n_state = S_SEG_END;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SEG_RD;
                end
            end
            S_SEG_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_seg = 1'b1;
                n_state      = S_SEG_WR;
            end
            S_SEG_WR: begin
                o_cmd.chunk_wr = 1'b1;
                if (i_stat.seg_wr_last) begin
                    n_state = S_SEG_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SEG_RD;
                end
            end
            S_SEG_END: begin
                if (i_stat.seg_done) begin
                    o_cmd.asm_clr = 1'b1;
                    n_state       = S_ASM;
                end else begin
                    o_cmd.frame_clr = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_ASM: begin
                o_cmd.asm_step = 1'b1;
                if (i_stat.asm_last) begin
                    n_state = S_SEG_EMIT;
                end
            end
            S_SEG_EMIT: begin
                o_cmd.ekind = K_SEGMENT;
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.frame_clr = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/bridge_frame_decoder_unit.sv
// Top level of the bridge frame decoder: configuration registers and the two halves.
//
// Input stream: one frame byte per word on s_axis_tdata, s_axis_tlast on the last
// byte of a bus transaction. Output stream: decoded events, kind on m_axis_tuser,
// m_axis_tlast on the final event of a frame. Configuration through the APB port:
// full scale at address 0, segment module number at address 4; write only while idle.
// A byte that does not end a frame is taken while idle, and the input stays ready
// for the next one. The end byte starts the decode, during which no byte is taken.
// A digital, output, invalid or dropped event goes to the output register from the
// check state; an analog event waits for the bit-serial divider; each group event
// follows its own frame memory read; segment text is copied one chunk byte at a
// time and then assembled into digits before it is emitted. A frame that decodes
// to nothing frees the input without an event.
// The result sits in an output register, so a stalled receiver holds the decode at
// its next event while bytes of a following frame are still taken once it is idle.
// Reset clears the byte count, checksum, segment state and chunk store, sets all
// digits to spaces and the registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module bridge_frame_decoder_unit
    import bfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME   = MAX_FRAME_DEF,
    parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // data_byte
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // frame_type, module_res, channel, value, bit_group, raw, percent_tenths,
    // text_high, text_low, zero fill
    output logic [DATA_W-1:0]      m_axis_tdata,
    output logic [2:0]             m_axis_tuser,   // kind
    output logic                   m_axis_tlast,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_full_scale;
    logic [7:0]  r_seg_id;
    t_cmd        cmd;
    t_stat       stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FULL_SCALE_RST;
            r_seg_id     <= SEG_ID_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_FULL_SCALE) begin
                r_full_scale <= pwdata[15:0];
            end else begin
                r_seg_id <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SEG_ID) ? {24'd0, r_seg_id} : {16'd0, r_full_scale};

    bfd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .i_tlast  (s_axis_tlast),
        .o_tready (s_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    bfd_datapath #(
        .MAX_FRAME   (MAX_FRAME),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_data       (s_axis_tdata),
        .i_full_scale (r_full_scale),
        .i_seg_id     (r_seg_id),
        .i_tready     (m_axis_tready),
        .o_tvalid     (m_axis_tvalid),
        .o_tuser      (m_axis_tuser),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast)
    );

endmodule
`default_nettype wire
